/* sv/gf2mu_pkg.sv */
// ----------------------------------------------------------------------------
// gf2mu_pkg
// Shared types, constants and helper functions of the GF(2) matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2mu_pkg;

	localparam int MAX_DIM    = 16;
	localparam int ROW_W      = 16;
	localparam int IDX_W      = 4;
	localparam int DEPTH      = 2 ** IDX_W;
	localparam int DIM_W      = 5;
	localparam int OP_W       = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int S_TDATA_W  = 24;
	localparam int S_TUSER_W  = OP_W;
	localparam int M_TDATA_W  = 24;
	localparam int DIM_LIMIT  = (MAX_DIM < DEPTH) ? MAX_DIM : DEPTH;

	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam dim_t DIM_MAX = dim_t'(DIM_LIMIT);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_A = 3'd0,
		OP_LOAD_B = 3'd1,
		OP_MUL    = 3'd2,
		OP_ADD    = 3'd3,
		OP_TRANS  = 3'd4,
		OP_CMP    = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		op_t  op;
		idx_t idx;
		logic scan;
		logic scan_clr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic idx_last;
		logic item_last;
	} status_t;

	// A size of zero counts as one, a size above the limit as the limit.
	function automatic dim_t eff_dim(input dim_t v);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic row_t col_mask(input dim_t n);
		row_t m;
		for (int c = 0; c < ROW_W; c++) begin
			m[c] = (dim_t'(c) < n);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

/* sv/gf2mu_ctrl.sv */
// ----------------------------------------------------------------------------
// gf2mu_ctrl
// Command sequencer: accepts requests, steps the row counter and tells the
// datapath when to write, scan and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2mu_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [gf2mu_pkg::OP_W-1:0]    opcode,
	output gf2mu_pkg::cmd_t                    cmd,
	input  wire gf2mu_pkg::status_t            status
);
	import gf2mu_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROWS,
		S_SCAN
	} state_t;

	state_t state_q;
	op_t    op_q;
	idx_t   cnt_q;
	op_t    op_in;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign op_in    = op_t'(opcode);

	always_comb begin
		cmd          = '0;
		cmd.op       = op_q;
		cmd.idx      = cnt_q;
		cmd.wr_a     = accept && (op_in == OP_LOAD_A);
		cmd.wr_b     = accept && (op_in == OP_LOAD_B);
		cmd.scan_clr = accept && (op_in == OP_CMP);
		cmd.scan     = (state_q == S_SCAN);
		cmd.emit     = (state_q == S_ROWS) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_LOAD_A;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= op_in;
						cnt_q <= '0;
						case (op_in)
							OP_MUL, OP_ADD, OP_TRANS: state_q <= S_ROWS;
							OP_CMP:                   state_q <= S_SCAN;
							default:                  state_q <= S_IDLE;
						endcase
					end
				end
				S_ROWS: begin
					if (status.out_free) begin
						if (status.item_last) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_SCAN: begin
					if (status.idx_last) begin
						state_q <= S_ROWS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/gf2mu_dpath.sv */
// ----------------------------------------------------------------------------
// gf2mu_dpath
// Matrix storage, size registers, row arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2mu_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [gf2mu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gf2mu_pkg::DIM_W-1:0]       cfg_data,
	input  wire logic [gf2mu_pkg::IDX_W-1:0]       load_row,
	input  wire logic [gf2mu_pkg::ROW_W-1:0]       load_bits,
	input  wire gf2mu_pkg::cmd_t                   cmd,
	output gf2mu_pkg::status_t                     status,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [gf2mu_pkg::IDX_W-1:0]            out_row,
	output logic [gf2mu_pkg::ROW_W-1:0]            out_bits,
	output logic                                   equal_flag,
	output logic                                   size_error,
	output logic                                   last_row
);
	import gf2mu_pkg::*;

	row_t a_rows_q [DEPTH];
	row_t b_rows_q [DEPTH];
	dim_t a_row_cnt_q, a_col_cnt_q, b_row_cnt_q, b_col_cnt_q;
	logic mism_q;
	logic out_valid_q;
	idx_t out_row_q;
	row_t out_bits_q;
	logic equal_q, error_q, last_q;

	dim_t ar, ac, br, bc;
	row_t mask_ar, mask_ac, mask_bc;
	row_t arow, brow, sum, prod, trans, res;
	logic [ROW_W-1:0] mul_terms [ROW_W];
	idx_t cnt_last;
	logic idx_last, single, is_cmp, sizes_eq, diff_any;

	assign ar = eff_dim(a_row_cnt_q);
	assign ac = eff_dim(a_col_cnt_q);
	assign br = eff_dim(b_row_cnt_q);
	assign bc = eff_dim(b_col_cnt_q);

	assign mask_ar = col_mask(ar);
	assign mask_ac = col_mask(ac);
	assign mask_bc = col_mask(bc);

	assign arow = a_rows_q[cmd.idx];
	assign brow = b_rows_q[cmd.idx];
	assign sum  = (arow ^ brow) & mask_ac;
	assign diff_any = |sum;

	always_comb begin
		for (int c = 0; c < ROW_W; c++) begin
			for (int j = 0; j < ROW_W; j++) begin
				mul_terms[c][j] = arow[j] & mask_ac[j] & b_rows_q[j][c];
			end
		end
		for (int c = 0; c < ROW_W; c++) begin
			prod[c] = ^mul_terms[c];
		end
		for (int i = 0; i < ROW_W; i++) begin
			trans[i] = a_rows_q[i][cmd.idx] & mask_ar[i];
		end
	end

	always_comb begin
		case (cmd.op)
			OP_MUL:   res = prod & mask_bc;
			OP_ADD:   res = sum;
			OP_TRANS: res = trans;
			default:  res = '0;
		endcase
	end

	assign cnt_last = (cmd.op == OP_TRANS) ? idx_t'(ac - 1'b1) : idx_t'(ar - 1'b1);
	assign idx_last = (cmd.idx == cnt_last);
	assign sizes_eq = (ar == br) && (ac == bc);
	assign is_cmp   = (cmd.op == OP_CMP);
	assign single   = ((cmd.op == OP_MUL) && (ac != br)) ||
	                  ((cmd.op == OP_ADD) && !sizes_eq);

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.idx_last  = idx_last;
	assign status.item_last = single || is_cmp || idx_last;

	always_ff @(posedge clk) begin
		if (cmd.wr_a && (dim_t'(load_row) < DIM_MAX)) begin
			a_rows_q[load_row] <= load_bits;
		end
		if (cmd.wr_b && (dim_t'(load_row) < DIM_MAX)) begin
			b_rows_q[load_row] <= load_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_row_cnt_q <= dim_t'(1);
			a_col_cnt_q <= dim_t'(1);
			b_row_cnt_q <= dim_t'(1);
			b_col_cnt_q <= dim_t'(1);
			mism_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_A_ROWS: a_row_cnt_q <= cfg_data;
					REG_A_COLS: a_col_cnt_q <= cfg_data;
					REG_B_ROWS: b_row_cnt_q <= cfg_data;
					REG_B_COLS: b_col_cnt_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.scan_clr) begin
				mism_q <= 1'b0;
			end else if (cmd.scan) begin
				mism_q <= mism_q | diff_any;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (single || is_cmp) begin
				out_row_q  <= '0;
				out_bits_q <= '0;
				equal_q    <= is_cmp && sizes_eq && !mism_q;
				error_q    <= single;
				last_q     <= 1'b1;
			end else begin
				out_row_q  <= cmd.idx;
				out_bits_q <= res;
				equal_q    <= 1'b0;
				error_q    <= 1'b0;
				last_q     <= idx_last;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_bits   = out_bits_q;
	assign equal_flag = equal_q;
	assign size_error = error_q;
	assign last_row   = last_q;

endmodule

`default_nettype wire

/* sv/gf2_matrix_unit.sv */
// ----------------------------------------------------------------------------
// gf2_matrix_unit
// Two 16x16 bit matrices over GF(2) with multiply, add, transpose and compare.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: s_tuser carries the opcode, s_tdata the
// load row index and packed row bits. Loads of A or B give no result.
// Multiply, add and transpose emit one result row per cycle on the m_ channel
// unless the receiver stalls; m_tlast marks the final row. A size mismatch on
// multiply or add gives a single result with the error bit in m_tuser.
// Compare scans one row of A and B per cycle over the rows in use and then
// gives one result with the equal flag. The row counter sets this rate: a
// new request is taken once the last row has entered the output register.
// Configuration writes on the cfg_ channel set the four sizes and are always
// taken; the user must issue them only while the block is idle, which the
// block itself does not enforce. Reset sets every size to one and empties
// the output register; matrix contents are undefined until loaded. When the
// receiver stalls, the current row holds in the output register and the row
// counter waits.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_matrix_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// load_row [3:0], load_bits [19:4], unused [23:20]
	input  wire logic [gf2mu_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode [2:0]
	input  wire logic [gf2mu_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// out_row [3:0], out_bits [19:4], equal_flag [20], zero fill [23:21]
	output logic [gf2mu_pkg::M_TDATA_W-1:0]          m_tdata,
	// size_error [0]
	output logic                                     m_tuser,
	output logic                                     m_tlast,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gf2mu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gf2mu_pkg::DIM_W-1:0]         cfg_data
);
	import gf2mu_pkg::*;

	cmd_t    cmd;
	status_t status;
	idx_t    out_row;
	row_t    out_bits;
	logic    equal_flag;

	assign cfg_ready = 1'b1;

	gf2mu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser[OP_W-1:0]),
		.cmd      (cmd),
		.status   (status)
	);

	gf2mu_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.load_row   (s_tdata[IDX_W-1:0]),
		.load_bits  (s_tdata[IDX_W+ROW_W-1:IDX_W]),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_row    (out_row),
		.out_bits   (out_bits),
		.equal_flag (equal_flag),
		.size_error (m_tuser),
		.last_row   (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_W - IDX_W - ROW_W - 1){1'b0}}, equal_flag, out_bits, out_row};

endmodule

`default_nettype wire
